// ===== hw/rtl/opcp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package opcp_pkg;

    // Default spill buffer depth (columns per run)
    localparam int MaxColumnsDefault = 16;

    // Bus bytes
    localparam logic [7:0] CTRL_CMD   = 8'h00;
    localparam logic [7:0] CTRL_DATA  = 8'h40;
    localparam logic [7:0] CMD_PAGE   = 8'hB0;
    localparam logic [7:0] CMD_COL_HI = 8'h10;
    localparam logic [7:0] COL_MOD    = 8'd127;
    localparam logic [7:0] COL_MOD2   = 8'd254;

    // Microprogram step addresses
    localparam logic [2:0] PC_POS0 = 3'd0;
    localparam logic [2:0] PC_POS1 = 3'd1;
    localparam logic [2:0] PC_POS2 = 3'd2;
    localparam logic [2:0] PC_POS3 = 3'd3;
    localparam logic [2:0] PC_POS4 = 3'd4;
    localparam logic [2:0] PC_DATA = 3'd5;
    localparam logic [2:0] PC_SRD  = 3'd6;
    localparam logic [2:0] PC_SEM  = 3'd7;

    // Output byte source
    typedef enum logic [2:0] {
        SEL_CMD,
        SEL_PAGE,
        SEL_COLLO,
        SEL_COLHI,
        SEL_DAT_CTL,
        SEL_DATA,
        SEL_SPILL
    } t_sel;

    // Jump kind at the end of a step
    typedef enum logic [1:0] {
        J_NEXT,
        J_PHASE,
        J_TAIL,
        J_LOOP
    } t_jmp;

    // One control word
    typedef struct packed {
        logic emit;
        logic gate;   // emission suppressed when the column is dropped
        logic start;
        t_sel sel;
        t_jmp jmp;
    } t_cw;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic drop;
        logic last;
        logic shift_nz;
        logic more;
    } t_stat;

    // Sequencer controls handed to the datapath
    typedef struct packed {
        logic busy;
        logic emit;
        logic start;
        t_sel sel;
        logic second;
        logic finish;
    } t_ctrl;

    // Microprogram
    function automatic t_cw ucode(input logic [2:0] pc);
        t_cw cw;
        unique case (pc)
            PC_POS0: cw = '{emit: 1'b1, gate: 1'b0, start: 1'b1, sel: SEL_CMD,     jmp: J_NEXT};
            PC_POS1: cw = '{emit: 1'b1, gate: 1'b0, start: 1'b0, sel: SEL_PAGE,    jmp: J_NEXT};
            PC_POS2: cw = '{emit: 1'b1, gate: 1'b0, start: 1'b0, sel: SEL_COLLO,   jmp: J_NEXT};
            PC_POS3: cw = '{emit: 1'b1, gate: 1'b0, start: 1'b0, sel: SEL_COLHI,   jmp: J_NEXT};
            PC_POS4: cw = '{emit: 1'b1, gate: 1'b0, start: 1'b1, sel: SEL_DAT_CTL, jmp: J_PHASE};
            PC_DATA: cw = '{emit: 1'b1, gate: 1'b1, start: 1'b0, sel: SEL_DATA,    jmp: J_TAIL};
            PC_SRD:  cw = '{emit: 1'b0, gate: 1'b0, start: 1'b0, sel: SEL_SPILL,   jmp: J_NEXT};
            PC_SEM:  cw = '{emit: 1'b1, gate: 1'b0, start: 1'b0, sel: SEL_SPILL,   jmp: J_LOOP};
            default: cw = '{emit: 1'b0, gate: 1'b0, start: 1'b0, sel: SEL_CMD,     jmp: J_NEXT};
        endcase
        return cw;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/opcp_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface opcp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] col_x;
    logic [7:0] row_y;
    logic [7:0] column_byte;
    logic       last_column;

    modport source (output valid, col_x, row_y, column_byte, last_column, input ready);
    modport sink   (input valid, col_x, row_y, column_byte, last_column, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/opcp_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface opcp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       transfer_start;
    logic       last_result;
    logic       overflow;

    modport source (output valid, out_byte, transfer_start, last_result, overflow, input ready);
    modport sink   (input valid, out_byte, transfer_start, last_result, overflow, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/oled_page_column_placer.sv =====
// A beat is taken only while the sequencer is idle; it then runs one
// microprogram step per cycle, stalled while the output register holds an
// untaken byte. A run-opening column emits the command transfer, data
// control and data byte, a middle column its data byte; a last column with
// nonzero shift adds a second transfer and its buffered spill bytes.
// Reset: synchronous active-low clears run state and output valid.
`timescale 1ns / 1ps
`default_nettype none
module oled_page_column_placer #(
    parameter int MAX_COLUMNS = opcp_pkg::MaxColumnsDefault
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    opcp_in_if.sink     i_in,
    opcp_out_if.source  o_out
);
    import opcp_pkg::*;

    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int IW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    t_ctrl          w_ctrl;
    t_stat          w_stat;
    logic           w_accept;
    logic           w_adv;

    // Run state
    logic           r_in_run;
    logic [2:0]     r_page;
    logic [2:0]     r_shift;
    logic [6:0]     r_col;
    logic [CW-1:0]  r_count;
    logic           r_ovf;

    // Per-item state
    logic           r_drop;
    logic           r_last;
    logic           r_flag;
    logic [7:0]     r_data;
    logic [7:0]     r_spill;
    logic [IW-1:0]  r_idx;
    logic [7:0]     r_rd;

    // Output register
    logic           r_out_valid;
    logic [7:0]     r_out_byte;
    logic           r_out_start;
    logic           r_out_last;
    logic           r_out_ovf;

    logic [7:0]     mem [MAX_COLUMNS];

    // Accept-time arithmetic
    logic [2:0]     w_shift;
    logic [15:0]    w_wide;
    logic [7:0]     w_colx;
    logic           w_keep;
    logic [7:0]     w_byte;
    logic [2:0]     w_page;

    assign w_accept = i_in.valid && i_in.ready;
    assign i_in.ready = i_rst_n && !w_ctrl.busy;
    assign w_adv = w_ctrl.busy && (!r_out_valid || o_out.ready);

    assign w_shift = r_in_run ? r_shift : i_in.row_y[2:0];
    assign w_wide  = {8'h00, i_in.column_byte} << w_shift;
    assign w_keep  = !r_in_run || (r_count < CW'(MAX_COLUMNS));

    // Column mod 127 over an 8-bit value
    always_comb begin
        priority if (i_in.col_x >= COL_MOD2) begin
            w_colx = i_in.col_x - COL_MOD2;
        end else if (i_in.col_x >= COL_MOD) begin
            w_colx = i_in.col_x - COL_MOD;
        end else begin
            w_colx = i_in.col_x;
        end
    end

    assign w_stat.drop     = r_drop;
    assign w_stat.last     = r_last;
    assign w_stat.shift_nz = (r_shift != 3'd0);
    assign w_stat.more     = (CW'(r_idx) + CW'(1)) < r_count;

    opcp_seq u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_in_run (r_in_run),
        .i_adv    (w_adv),
        .i_stat   (w_stat),
        .o_ctrl   (w_ctrl)
    );

    // Run state and per-item latches
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run <= 1'b0;
            r_page   <= 3'd0;
            r_shift  <= 3'd0;
            r_col    <= 7'd0;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_drop   <= 1'b0;
            r_last   <= 1'b0;
            r_flag   <= 1'b0;
        end else if (w_accept) begin
            r_drop <= !w_keep;
            r_last <= i_in.last_column;
            if (!r_in_run) begin
                r_in_run <= 1'b1;
                r_page   <= i_in.row_y[5:3];
                r_shift  <= i_in.row_y[2:0];
                r_col    <= w_colx[6:0];
                r_count  <= '0;
                r_ovf    <= 1'b0;
                r_flag   <= 1'b0;
            end else begin
                r_ovf  <= r_ovf || !w_keep;
                r_flag <= r_ovf || !w_keep;
            end
        end else if (w_adv) begin
            if (w_ctrl.finish && r_last) begin
                r_in_run <= 1'b0;
                r_count  <= '0;
                r_ovf    <= 1'b0;
            end else if (w_ctrl.emit && w_ctrl.sel == SEL_DATA) begin
                r_count <= r_count + CW'(1);
            end
        end
    end

    // Payload latches and spill index
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data  <= w_wide[7:0];
            r_spill <= w_wide[15:8];
            r_idx   <= '0;
        end else if (w_adv && w_ctrl.emit && w_ctrl.sel == SEL_SPILL) begin
            r_idx <= r_idx + IW'(1);
        end
    end

    // Spill buffer: written on a kept column with nonzero shift, read ahead of each spill byte
    always_ff @(posedge i_clk) begin
        if (w_adv && w_ctrl.emit && w_ctrl.sel == SEL_DATA && r_shift != 3'd0) begin
            mem[r_count[IW-1:0]] <= r_spill;
        end
        if (w_adv && !w_ctrl.emit && w_ctrl.sel == SEL_SPILL) begin
            r_rd <= mem[r_idx];
        end
    end

    // Byte select
    assign w_page = w_ctrl.second ? (r_page + 3'd1) : r_page;
    always_comb begin
        unique case (w_ctrl.sel)
            SEL_CMD:     w_byte = CTRL_CMD;
            SEL_PAGE:    w_byte = CMD_PAGE + {5'd0, w_page};
            SEL_COLLO:   w_byte = {4'h0, r_col[3:0]};
            SEL_COLHI:   w_byte = CMD_COL_HI + {5'd0, r_col[6:4]};
            SEL_DAT_CTL: w_byte = CTRL_DATA;
            SEL_DATA:    w_byte = r_data;
            SEL_SPILL:   w_byte = r_rd;
            default:     w_byte = CTRL_CMD;
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_ctrl.emit) begin
            r_out_byte  <= w_byte;
            r_out_start <= w_ctrl.start;
            r_out_last  <= w_ctrl.finish;
            r_out_ovf   <= r_flag;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.out_byte       = r_out_byte;
    assign o_out.transfer_start = r_out_start;
    assign o_out.last_result    = r_out_last;
    assign o_out.overflow       = r_out_ovf;

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_COLUMNS))
        else $error("spill count beyond buffer depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_ctrl.busy)
        else $error("sequencer idle after beat taken");

    a_first_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !r_in_run) |=> !r_drop)
        else $error("run-opening column dropped");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_run |-> (r_count == '0 && !r_ovf))
        else $error("run state left over outside a run");

endmodule
`default_nettype wire

// ===== hw/rtl/opcp_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
module opcp_seq (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire              i_in_run,
    input  wire              i_adv,
    input  opcp_pkg::t_stat  i_stat,
    output opcp_pkg::t_ctrl  o_ctrl
);
    import opcp_pkg::*;

    logic [2:0] r_pc;
    logic [2:0] n_pc;
    logic       r_second;
    logic       n_second;
    logic       r_busy;
    logic       w_finish;
    t_cw        w_cw;

    assign w_cw = ucode(r_pc);

    // Jump resolution
    always_comb begin
        n_pc     = r_pc + 3'd1;
        n_second = r_second;
        w_finish = 1'b0;
        unique case (w_cw.jmp)
            J_NEXT: begin
                n_pc = r_pc + 3'd1;
            end
            J_PHASE: begin
                n_pc = r_second ? PC_SRD : PC_DATA;
            end
            J_TAIL: begin
                if (i_stat.last && i_stat.shift_nz) begin
                    n_pc     = PC_POS0;
                    n_second = 1'b1;
                end else begin
                    w_finish = 1'b1;
                end
            end
            J_LOOP: begin
                if (i_stat.more) begin
                    n_pc = PC_SRD;
                end else begin
                    w_finish = 1'b1;
                end
            end
            default: begin
                w_finish = 1'b1;
            end
        endcase
    end

    // Step counter and phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= PC_POS0;
            r_second <= 1'b0;
            r_busy   <= 1'b0;
        end else if (i_start) begin
            r_pc     <= i_in_run ? PC_DATA : PC_POS0;
            r_second <= 1'b0;
            r_busy   <= 1'b1;
        end else if (i_adv) begin
            r_pc     <= n_pc;
            r_second <= n_second;
            r_busy   <= !w_finish;
        end
    end

    assign o_ctrl.busy   = r_busy;
    assign o_ctrl.emit   = w_cw.emit && !(w_cw.gate && i_stat.drop);
    assign o_ctrl.start  = w_cw.start;
    assign o_ctrl.sel    = w_cw.sel;
    assign o_ctrl.second = r_second;
    assign o_ctrl.finish = w_finish;

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
    import opcp_pkg::*;

    localparam int SpillDepth   = MaxColumnsDefault;
    localparam int RandomItems  = 235;
    localparam int HoldCycles   = 300;
    localparam int DrainCycles  = 40;

    // One output beat as the bus sees it
    typedef struct packed {
        logic [7:0] out_byte;
        logic       transfer_start;
        logic       last_result;
        logic       overflow;
    } bus_beat_t;

    // Directed stimulus row; typed fields hold a result read off by hand
    typedef struct packed {
        logic [7:0] col_x;
        logic [7:0] row_y;
        logic [7:0] column_byte;
        logic       last_column;
        logic       typed;
        logic [4:0] beats_typed;
        logic [7:0] tail_typed;
        logic       ovf_typed;
    } placement_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    opcp_in_if  in_if();
    opcp_out_if out_if();

    oled_page_column_placer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Placement state mirrored from the block
    logic       run_open;
    logic [2:0] page_q;
    logic [2:0] shift_q;
    logic [6:0] column_q;
    logic [7:0] spill_q [SpillDepth];
    int         spill_n;
    logic       overflow_q;

    bus_beat_t  item_beats[$];
    bus_beat_t  bus_beats_q[$];

    int          err_cnt       = 0;
    int unsigned send_idle_pct = 6;
    int unsigned recv_idle_pct = 66;
    bit          hold_req      = 1'b0;

    placement_row_t dir_rows [25] = '{
        '{8'h00, 8'h00, 8'hFF, 1'b1, 1'b1, 5'd6,  8'hFF, 1'b0},
        '{8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 5'd12, 8'h7F, 1'b0},
        '{8'h7F, 8'h08, 8'h81, 1'b0, 1'b1, 5'd6,  8'h81, 1'b0},
        '{8'hFF, 8'hFF, 8'h00, 1'b0, 1'b1, 5'd1,  8'h00, 1'b0},
        '{8'h00, 8'h00, 8'h55, 1'b1, 1'b1, 5'd1,  8'h55, 1'b0},
        '{8'h7E, 8'h03, 8'hAA, 1'b0, 1'b1, 5'd6,  8'h50, 1'b0},
        '{8'h05, 8'hC8, 8'hFF, 1'b1, 1'b1, 5'd8,  8'h07, 1'b0},
        // run that overruns the spill buffer, zero shift
        '{8'hC8, 8'h10, 8'h01, 1'b0, 1'b1, 5'd6,  8'h01, 1'b0},
        '{8'h00, 8'h00, 8'h02, 1'b0, 1'b1, 5'd1,  8'h02, 1'b0},
        '{8'h00, 8'h00, 8'h04, 1'b0, 1'b1, 5'd1,  8'h04, 1'b0},
        '{8'h00, 8'h00, 8'h08, 1'b0, 1'b1, 5'd1,  8'h08, 1'b0},
        '{8'h00, 8'h00, 8'h10, 1'b0, 1'b1, 5'd1,  8'h10, 1'b0},
        '{8'h00, 8'h00, 8'h20, 1'b0, 1'b1, 5'd1,  8'h20, 1'b0},
        '{8'h00, 8'h00, 8'h40, 1'b0, 1'b1, 5'd1,  8'h40, 1'b0},
        '{8'h00, 8'h00, 8'h80, 1'b0, 1'b1, 5'd1,  8'h80, 1'b0},
        '{8'h00, 8'h00, 8'hFE, 1'b0, 1'b1, 5'd1,  8'hFE, 1'b0},
        '{8'h00, 8'h00, 8'hFD, 1'b0, 1'b1, 5'd1,  8'hFD, 1'b0},
        '{8'h00, 8'h00, 8'hFB, 1'b0, 1'b1, 5'd1,  8'hFB, 1'b0},
        '{8'h00, 8'h00, 8'hF7, 1'b0, 1'b1, 5'd1,  8'hF7, 1'b0},
        '{8'h00, 8'h00, 8'hEF, 1'b0, 1'b1, 5'd1,  8'hEF, 1'b0},
        '{8'h00, 8'h00, 8'hDF, 1'b0, 1'b1, 5'd1,  8'hDF, 1'b0},
        '{8'h00, 8'h00, 8'hBF, 1'b0, 1'b1, 5'd1,  8'hBF, 1'b0},
        '{8'h00, 8'h00, 8'h7F, 1'b0, 1'b1, 5'd1,  8'h7F, 1'b0},
        // dropped column, then dropped last column: no beats at all
        '{8'h00, 8'h00, 8'hFF, 1'b0, 1'b1, 5'd0,  8'h00, 1'b0},
        '{8'h00, 8'h00, 8'hAA, 1'b1, 1'b1, 5'd0,  8'h00, 1'b0}
    };

    task automatic push_byte(input logic [7:0] value, input logic opens);
        bus_beat_t bt;
        bt.out_byte       = value;
        bt.transfer_start = opens;
        bt.last_result    = 1'b0;
        bt.overflow       = 1'b0;
        item_beats.push_back(bt);
    endtask

    // Command transfer: control, page, column low and high nibbles
    task automatic push_position(input logic [2:0] page);
        push_byte(CTRL_CMD, 1'b1);
        push_byte(CMD_PAGE + {5'b0, page}, 1'b0);
        push_byte({4'h0, column_q[3:0]}, 1'b0);
        push_byte(CMD_COL_HI + {5'b0, column_q[6:4]}, 1'b0);
    endtask

    // Works out the beats one column byte causes and queues them
    task automatic place_column(input logic [7:0] x, input logic [7:0] y,
                                input logic [7:0] b, input logic last);
        logic [15:0] widened;
        logic        flag;
        int          i;
        item_beats.delete();
        if (!run_open) begin
            run_open   = 1'b1;
            page_q     = y[5:3];
            shift_q    = y[2:0];
            column_q   = 7'(int'(x) % int'(COL_MOD));
            spill_n    = 0;
            overflow_q = 1'b0;
            push_position(page_q);
            push_byte(CTRL_DATA, 1'b1);
        end
        if (spill_n < SpillDepth) begin
            widened = {8'h00, b} << shift_q;
            push_byte(widened[7:0], 1'b0);
            if (shift_q != 3'd0)
                spill_q[spill_n] = widened[15:8];
            spill_n++;
        end else begin
            overflow_q = 1'b1;
        end
        flag = overflow_q;
        if (last) begin
            if (shift_q != 3'd0) begin
                push_position(page_q + 3'd1);
                push_byte(CTRL_DATA, 1'b1);
                for (i = 0; i < spill_n; i++)
                    push_byte(spill_q[i], 1'b0);
            end
            run_open   = 1'b0;
            spill_n    = 0;
            overflow_q = 1'b0;
        end
        foreach (item_beats[k])
            item_beats[k].overflow = flag;
        if (item_beats.size() > 0)
            item_beats[item_beats.size() - 1].last_result = 1'b1;
        foreach (item_beats[k])
            bus_beats_q.push_back(item_beats[k]);
    endtask

    // Offers one column beat, with random idle cycles, until it is taken
    task automatic offer_column(input logic [7:0] x, input logic [7:0] y,
                                input logic [7:0] b, input logic last);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid       <= 1'b1;
        in_if.col_x       <= x;
        in_if.row_y       <= y;
        in_if.column_byte <= b;
        in_if.last_column <= last;
        do @(posedge clk); while (!in_if.ready);
        place_column(x, y, b, last);
    endtask

    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            err_cnt++;
        end
    endtask

    // Output checker
    always @(posedge clk) begin
        bus_beat_t want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (bus_beats_q.size() == 0) begin
                $error("out_byte: expected none, got %0h", out_if.out_byte);
                err_cnt++;
            end else begin
                want = bus_beats_q.pop_front();
                check_field("out_byte", want.out_byte, out_if.out_byte);
                check_field("transfer_start", {7'b0, want.transfer_start},
                            {7'b0, out_if.transfer_start});
                check_field("last_result", {7'b0, want.last_result},
                            {7'b0, out_if.last_result});
                check_field("overflow", {7'b0, want.overflow}, {7'b0, out_if.overflow});
            end
        end
    end

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_if.ready <= 1'b0;
                repeat (HoldCycles) @(negedge clk);
                hold_req = 1'b0;
            end
            out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Main stimulus
    initial begin
        int  sent;
        int  run_len;
        int  pick;
        bit  noisy;
        bit  last;
        in_if.valid       = 1'b0;
        in_if.col_x       = 8'h00;
        in_if.row_y       = 8'h00;
        in_if.column_byte = 8'h00;
        in_if.last_column = 1'b0;
        run_open   = 1'b0;
        page_q     = 3'd0;
        shift_q    = 3'd0;
        column_q   = 7'd0;
        spill_n    = 0;
        overflow_q = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (dir_rows[r]) begin
            offer_column(dir_rows[r].col_x, dir_rows[r].row_y,
                         dir_rows[r].column_byte, dir_rows[r].last_column);
            if (dir_rows[r].typed) begin
                if (item_beats.size() != int'(dir_rows[r].beats_typed)) begin
                    $error("beat count row %0d: expected %0d, got %0d", r,
                           dir_rows[r].beats_typed, item_beats.size());
                    err_cnt++;
                end else if (item_beats.size() > 0) begin
                    check_field("tail out_byte", dir_rows[r].tail_typed,
                                item_beats[item_beats.size() - 1].out_byte);
                    check_field("tail overflow", {7'b0, dir_rows[r].ovf_typed},
                                {7'b0, item_beats[item_beats.size() - 1].overflow});
                end
            end
        end

        // random runs: mostly short, some long enough to overrun the buffer
        sent = 0;
        while (sent < RandomItems) begin
            if (sent >= RandomItems / 3 && send_idle_pct == 6) begin
                send_idle_pct = 66;
                recv_idle_pct = 6;
            end
            if (sent >= 2 * RandomItems / 3 && send_idle_pct == 66) begin
                // sender pauses until the bus has drained
                @(negedge clk);
                in_if.valid <= 1'b0;
                while (bus_beats_q.size() != 0) @(posedge clk);
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_req      = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
                run_len = $urandom_range(1, 5);
            else if (pick < 88)
                run_len = $urandom_range(6, 15);
            else
                run_len = $urandom_range(16, 20);
            noisy = ($urandom_range(0, 9) == 0);
            for (int k = 0; k < run_len; k++) begin
                last = (k == run_len - 1) || (noisy && $urandom_range(0, 4) == 0);
                offer_column(8'($urandom), 8'($urandom), 8'($urandom), last);
                sent++;
            end
        end

        @(negedge clk);
        in_if.valid <= 1'b0;
        while (bus_beats_q.size() != 0) @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
        if (err_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
